[hdl/chunk_bitmap_first_zero_last_one_top_defines.svh]
//------------------------------------------------------------------------------
// Assertion macros for the chunk bitmap block
// Shorthand for clocked assertions with an asynchronous active-low reset.
//------------------------------------------------------------------------------
`ifndef CHUNK_BITMAP_FIRST_ZERO_LAST_ONE_TOP_DEFINES_SVH
`define CHUNK_BITMAP_FIRST_ZERO_LAST_ONE_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define CBFZ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define CBFZ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/cbfz_pkg.sv]
//------------------------------------------------------------------------------
// Chunk bitmap package
// Shared constants, codes, control structs and bit search functions.
//------------------------------------------------------------------------------
`default_nettype none

package cbfz_pkg;

	localparam int MAP_BITS_DEF  = 4096;
	localparam int MAX_WORDS_DEF = 128;
	localparam int WORD_BITS     = 32;
	localparam int LANES         = 4;
	localparam int LANE_W        = 2;
	localparam int ROW_BITS      = LANES * WORD_BITS;
	localparam int ROW_POS_W     = 7;
	localparam int CNT_W         = 13;
	localparam int IDX_W         = 7;
	localparam int OP_W          = 2;
	localparam int S_DATA_W      = 40;
	localparam int M_DATA_W      = 64;
	localparam logic [CNT_W-1:0] BIT_COUNT_RST = 13'd4096;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_READ  = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_RDWAIT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic clr;
		logic wr;
		logic rd_word;
		logic scan_start;
		logic scan_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic no_words;
		logic scan_last;
		logic out_busy;
	} st_t;

	typedef struct packed {
		logic                 found;
		logic [ROW_POS_W-1:0] pos;
	} find_t;

	function automatic find_t first_zero(input logic [ROW_BITS-1:0] v);
		find_t r;
		r = '0;
		for (int k = ROW_BITS - 1; k >= 0; k--) begin
			if (!v[k]) begin
				r.found = 1'b1;
				r.pos   = ROW_POS_W'(k);
			end
		end
		return r;
	endfunction

	function automatic find_t last_one(input logic [ROW_BITS-1:0] v);
		find_t r;
		r = '0;
		for (int k = 0; k < ROW_BITS; k++) begin
			if (v[k]) begin
				r.found = 1'b1;
				r.pos   = ROW_POS_W'(k);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/cbfz_ctrl.sv]
//------------------------------------------------------------------------------
// Chunk bitmap controller
// Sequences accept, execute, row scan and result hand-off for one item.
//------------------------------------------------------------------------------
`default_nettype none

module cbfz_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire cbfz_pkg::st_t  st,
	output cbfz_pkg::cmd_t      cmd
);

	cbfz_pkg::state_t state_q;
	cbfz_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbfz_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		unique case (state_q)
			cbfz_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_nxt   = cbfz_pkg::S_EXEC;
				end
			end
			cbfz_pkg::S_EXEC: begin
				unique case (st.op)
					cbfz_pkg::OP_CLEAR: begin
						cmd.clr   = 1'b1;
						state_nxt = cbfz_pkg::S_FINISH;
					end
					cbfz_pkg::OP_LOAD: begin
						cmd.wr    = 1'b1;
						state_nxt = cbfz_pkg::S_FINISH;
					end
					cbfz_pkg::OP_READ: begin
						cmd.rd_word = 1'b1;
						state_nxt   = cbfz_pkg::S_RDWAIT;
					end
					cbfz_pkg::OP_QUERY: begin
						cmd.scan_start = 1'b1;
						state_nxt      = st.no_words ? cbfz_pkg::S_FINISH : cbfz_pkg::S_SCAN;
					end
					default: state_nxt = cbfz_pkg::S_FINISH;
				endcase
			end
			cbfz_pkg::S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (st.scan_last) begin
					state_nxt = cbfz_pkg::S_FINISH;
				end
			end
			cbfz_pkg::S_RDWAIT: begin
				state_nxt = cbfz_pkg::S_FINISH;
			end
			cbfz_pkg::S_FINISH: begin
				if (!st.out_busy) begin
					cmd.out_load = 1'b1;
					state_nxt    = cbfz_pkg::S_IDLE;
				end
			end
			default: state_nxt = cbfz_pkg::S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

[hdl/cbfz_dp.sv]
//------------------------------------------------------------------------------
// Chunk bitmap datapath
// Bitmap memory in rows of four words, row scan reduction and result register.
//------------------------------------------------------------------------------
`default_nettype none

module cbfz_dp #(
	parameter int MAP_BITS  = cbfz_pkg::MAP_BITS_DEF,
	parameter int MAX_WORDS = cbfz_pkg::MAX_WORDS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [cbfz_pkg::CNT_W-1:0]      cfg_wr_data,
	input  wire logic [cbfz_pkg::S_DATA_W-1:0]   s_tdata,
	input  wire logic [cbfz_pkg::OP_W-1:0]       s_tuser,
	input  wire cbfz_pkg::cmd_t                  cmd,
	output cbfz_pkg::st_t                        st,
	input  wire logic                            m_tready,
	output logic                                 m_tvalid,
	output logic [cbfz_pkg::M_DATA_W-1:0]        m_tdata
);

	localparam int ROWS = (MAX_WORDS + cbfz_pkg::LANES - 1) / cbfz_pkg::LANES;
	localparam int RA   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int WA   = RA + cbfz_pkg::LANE_W;
	localparam int PW   = (RA + cbfz_pkg::ROW_POS_W + 1 > 14) ? RA + cbfz_pkg::ROW_POS_W + 1 : 14;
	localparam logic [31:0] LIMIT_V = (MAP_BITS < MAX_WORDS * cbfz_pkg::WORD_BITS) ?
		32'(MAP_BITS) : 32'(MAX_WORDS * cbfz_pkg::WORD_BITS);
	localparam logic [15:0] MW_V = 16'(MAX_WORDS);

	logic [cbfz_pkg::CNT_W-1:0]      bit_count_q;
	cbfz_pkg::op_t                   op_q;
	logic [cbfz_pkg::IDX_W-1:0]      idx_q;
	logic [cbfz_pkg::WORD_BITS-1:0]  val_q;

	logic [cbfz_pkg::ROW_BITS-1:0]   mem_q [ROWS];
	logic [ROWS*cbfz_pkg::LANES-1:0] vld_q;
	logic [cbfz_pkg::ROW_BITS-1:0]   rd_data_s1;
	logic [cbfz_pkg::LANES-1:0]      rd_vld_s1;
	logic [RA-1:0]                   rd_row_s1;
	logic [RA-1:0]                   row_q;

	logic                            lo_found_q;
	logic [PW-1:0]                   lo_pos_q;
	logic                            hi_found_q;
	logic [PW-1:0]                   hi_pos_q;

	logic                            out_vld_q;
	logic [cbfz_pkg::M_DATA_W-1:0]   out_data_q;

	logic [cbfz_pkg::CNT_W-1:0]      eff;
	logic [13:0]                     eff_sum;
	logic [8:0]                      words;
	logic [15:0]                     words16;
	logic [15:0]                     words_m1;
	logic [15:0]                     idx16;
	logic [WA-1:0]                   idx_wa;
	logic [RA-1:0]                   idx_row;
	logic [cbfz_pkg::LANE_W-1:0]     idx_lane;
	logic                            idx_ok;
	logic [RA-1:0]                   last_row;
	logic [RA-1:0]                   rd_addr;
	logic                            rd_en;
	logic [cbfz_pkg::ROW_BITS-1:0]   zrow;
	logic [cbfz_pkg::ROW_BITS-1:0]   srow;
	cbfz_pkg::find_t                 fz;
	cbfz_pkg::find_t                 fo;
	logic [PW-1:0]                   row_base;
	logic [PW-1:0]                   lim_lo;
	logic [PW-1:0]                   lo_fin;
	logic [cbfz_pkg::WORD_BITS-1:0]  rd_word;
	logic [cbfz_pkg::CNT_W-1:0]      res_lo;
	logic [cbfz_pkg::CNT_W-1:0]      res_hi;
	logic [cbfz_pkg::WORD_BITS-1:0]  res_data;
	logic                            res_err;

	assign eff      = ({19'd0, bit_count_q} > LIMIT_V) ? LIMIT_V[cbfz_pkg::CNT_W-1:0] : bit_count_q;
	assign eff_sum  = {1'b0, eff} + 14'd31;
	assign words    = eff_sum[13:5];
	assign words16  = {7'd0, words};
	assign words_m1 = words16 - 16'd1;
	assign last_row = words_m1[RA+1:2];
	assign idx16    = {9'd0, idx_q};
	assign idx_wa   = idx16[WA-1:0];
	assign idx_row  = idx_wa[WA-1:cbfz_pkg::LANE_W];
	assign idx_lane = idx_wa[cbfz_pkg::LANE_W-1:0];
	assign idx_ok   = (idx16 < words16) && (idx16 < MW_V);

	assign st.op        = op_q;
	assign st.no_words  = (words == 9'd0);
	assign st.scan_last = (row_q == last_row);
	assign st.out_busy  = out_vld_q && !m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q <= cbfz_pkg::BIT_COUNT_RST;
		end else if (cfg_wr_en) begin
			bit_count_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= cbfz_pkg::op_t'(s_tuser);
			idx_q <= s_tdata[cbfz_pkg::IDX_W-1:0];
			val_q <= s_tdata[cbfz_pkg::IDX_W +: cbfz_pkg::WORD_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.clr) begin
			vld_q <= '0;
		end else if (cmd.wr && idx_ok) begin
			vld_q[idx_wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr && idx_ok) begin
			mem_q[idx_row][idx_lane*cbfz_pkg::WORD_BITS +: cbfz_pkg::WORD_BITS] <= val_q;
		end
	end

	always_comb begin
		rd_en = cmd.scan_start || (cmd.scan_step && !st.scan_last) || cmd.rd_word;
		priority if (cmd.scan_start) begin
			rd_addr = '0;
		end else if (cmd.scan_step) begin
			rd_addr = row_q + RA'(1);
		end else begin
			rd_addr = idx_row;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
			rd_vld_s1  <= vld_q[rd_addr*cbfz_pkg::LANES +: cbfz_pkg::LANES];
			rd_row_s1  <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (cmd.scan_start) begin
			row_q <= '0;
		end else if (cmd.scan_step && !st.scan_last) begin
			row_q <= row_q + RA'(1);
		end
	end

	always_comb begin
		logic [15:0]                    w16;
		logic [cbfz_pkg::WORD_BITS-1:0] wv;
		zrow = '0;
		srow = '0;
		for (int l = 0; l < cbfz_pkg::LANES; l++) begin
			w16 = 16'({rd_row_s1, cbfz_pkg::LANE_W'(l)});
			wv  = rd_vld_s1[l] ? rd_data_s1[l*cbfz_pkg::WORD_BITS +: cbfz_pkg::WORD_BITS] : '0;
			if (w16 < words16) begin
				zrow[l*cbfz_pkg::WORD_BITS +: cbfz_pkg::WORD_BITS] = wv;
				srow[l*cbfz_pkg::WORD_BITS +: cbfz_pkg::WORD_BITS] = wv;
			end else begin
				zrow[l*cbfz_pkg::WORD_BITS +: cbfz_pkg::WORD_BITS] = '1;
			end
		end
		fz       = cbfz_pkg::first_zero(zrow);
		fo       = cbfz_pkg::last_one(srow);
		row_base = PW'({rd_row_s1, {cbfz_pkg::ROW_POS_W{1'b0}}}) + PW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_found_q <= 1'b0;
			hi_found_q <= 1'b0;
		end else if (cmd.scan_start) begin
			lo_found_q <= 1'b0;
			hi_found_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (fz.found) begin
				lo_found_q <= 1'b1;
			end
			if (fo.found) begin
				hi_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step) begin
			if (fz.found && !lo_found_q) begin
				lo_pos_q <= row_base + PW'(fz.pos);
			end
			if (fo.found) begin
				hi_pos_q <= row_base + PW'(fo.pos);
			end
		end
	end

	always_comb begin
		lim_lo  = PW'(eff) + PW'(1);
		lo_fin  = (lo_found_q && (lo_pos_q < lim_lo)) ? lo_pos_q : lim_lo;
		rd_word = rd_data_s1[idx_lane*cbfz_pkg::WORD_BITS +: cbfz_pkg::WORD_BITS];
		res_lo   = '0;
		res_hi   = '0;
		res_data = '0;
		res_err  = 1'b0;
		unique case (op_q)
			cbfz_pkg::OP_CLEAR: begin
			end
			cbfz_pkg::OP_LOAD: begin
				res_err = !idx_ok;
			end
			cbfz_pkg::OP_READ: begin
				res_err  = !idx_ok;
				res_data = (idx_ok && rd_vld_s1[idx_lane]) ? rd_word : '0;
			end
			cbfz_pkg::OP_QUERY: begin
				res_lo = lo_fin[cbfz_pkg::CNT_W-1:0];
				res_hi = hi_found_q ? hi_pos_q[cbfz_pkg::CNT_W-1:0] : '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {5'd0, res_err, res_data, res_hi, res_lo};
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

[hdl/chunk_bitmap_first_zero_last_one_top.sv]
//------------------------------------------------------------------------------
// Chunk bitmap first-zero / last-one top level
//
//   Channel   Direction  Payload
//   s_*       in         tuser: opcode; tdata: word_index, word_value
//   m_*       out        tdata: lowest_clear_bit, highest_set_bit, word_data,
//                        index_error
//   cfg_*     in         bit_count, written whenever cfg_wr_en is high
//
// One item is in work at a time. Clear and load go from accept through execute
// and finish back to idle; read adds a wait state after execute, and query scans
// ceil(words / 4) rows in between, one memory row of four words per cycle.
// Reset clears the map at once through per-word valid bits; bit_count resets
// to 4096. A result waits in the output register while m_tready is low, and
// the next item is still taken and held in its last state until that beat goes.
//------------------------------------------------------------------------------
`default_nettype none

module chunk_bitmap_first_zero_last_one_top #(
	parameter int MAP_BITS  = cbfz_pkg::MAP_BITS_DEF,
	parameter int MAX_WORDS = cbfz_pkg::MAX_WORDS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [cbfz_pkg::CNT_W-1:0]    cfg_wr_data,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// Fields from bit 0: word_index[6:0], word_value[38:7], zero pad.
	input  wire logic [cbfz_pkg::S_DATA_W-1:0] s_tdata,
	// Fields from bit 0: opcode[1:0].
	input  wire logic [cbfz_pkg::OP_W-1:0]     s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// Fields from bit 0: lowest_clear_bit[12:0], highest_set_bit[25:13],
	// word_data[57:26], index_error[58], zero pad.
	output logic [cbfz_pkg::M_DATA_W-1:0]      m_tdata
);

	cbfz_pkg::cmd_t cmd;
	cbfz_pkg::st_t  st;

	cbfz_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	cbfz_dp #(
		.MAP_BITS  (MAP_BITS),
		.MAX_WORDS (MAX_WORDS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.cmd         (cmd),
		.st          (st),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.m_tdata     (m_tdata)
	);

endmodule

`default_nettype wire

[hdl/cbfz_chk.sv]
//------------------------------------------------------------------------------
// Chunk bitmap port checker
// Watches the top level's ports for handshake and result consistency.
//------------------------------------------------------------------------------
`default_nettype none
`include "chunk_bitmap_first_zero_last_one_top_defines.svh"

module cbfz_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          s_tvalid,
	input wire logic                          s_tready,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [cbfz_pkg::M_DATA_W-1:0] m_tdata
);

	`CBFZ_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "Output beat changed while stalled")
	`CBFZ_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready, "Input taken again right after a beat")
	`CBFZ_ASSERT_NOW(a_err_fields, clk, arst_n, m_tvalid && m_tdata[58], (m_tdata[25:0] == 26'd0) && (m_tdata[57:26] == 32'd0), "Index error beat carries data")
	`CBFZ_ASSERT_NOW(a_out_rise, clk, arst_n, $rose(m_tvalid), s_tready && !$past(s_tready), "Result appeared outside item completion")

endmodule

bind chunk_bitmap_first_zero_last_one_top cbfz_chk u_chk (.*);

`default_nettype wire
